### hw/rtl/lprp_pkg.sv
// Shared types, byte codes and the result bundle of the length-prefixed record parser.
package lprp_pkg;

  localparam int SIZE_WIDTH_DEF = 32;
  localparam int CSIZE_W        = 32;
  localparam int OUT_TDATA_W    = 56;

  localparam logic [7:0] BAR_CHAR   = 8'h7C;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;
  localparam logic [7:0] DEC_BASE   = 8'd10;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_CONTENT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FLD_NAME = 2'd0,
    FLD_TYPE = 2'd1,
    FLD_SIZE = 2'd2
  } fld_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           data_byte;
    logic                 header_done;
    logic [7:0]           member_type;
    logic [CSIZE_W-1:0]   rec_size;
    logic                 size_overflow;
    logic                 record_done;
    logic                 record_discarded;
  } res_t;

endpackage

### hw/rtl/lprp_parser.sv
// Per-byte record parsing logic and the parser state registers.
module lprp_parser
  import lprp_pkg::*;
#(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_value,
  input  logic       start_of_string,
  output res_t       result
);

  localparam logic [SIZE_WIDTH-1:0] SIZE_ZERO = '0;
  localparam logic [SIZE_WIDTH-1:0] SIZE_ONE  = SIZE_WIDTH'(1);
  localparam logic [SIZE_WIDTH-1:0] SIZE_MAX  = '1;

  fld_t                  field_r, field_nxt;
  logic [7:0]            type_r, type_nxt;
  logic [SIZE_WIDTH-1:0] size_r, size_nxt;
  logic                  sat_r, sat_nxt;
  logic [SIZE_WIDTH-1:0] remain_r, remain_nxt;
  logic                  partial_r, partial_nxt;

  fld_t                  fld_cur;
  logic [7:0]            type_cur;
  logic [SIZE_WIDTH-1:0] size_cur;
  logic                  sat_cur;
  logic [SIZE_WIDTH-1:0] remain_cur;
  logic                  partial_cur;
  logic [7:0]            digit_full;
  logic [3:0]            digit;
  logic                  is_digit;
  logic [SIZE_WIDTH+3:0] size_prod;
  logic [SIZE_WIDTH+31:0] size_ext;

  assign digit_full = byte_value - DIGIT_LO;
  assign digit      = digit_full[3:0];
  assign is_digit   = (byte_value >= DIGIT_LO) && (byte_value <= DIGIT_HI);

  always_comb begin
    // A start flag clears the state before this byte is looked at.
    fld_cur     = start_of_string ? FLD_NAME  : field_r;
    type_cur    = start_of_string ? 8'd0      : type_r;
    size_cur    = start_of_string ? SIZE_ZERO : size_r;
    sat_cur     = start_of_string ? 1'b0      : sat_r;
    remain_cur  = start_of_string ? SIZE_ZERO : remain_r;
    partial_cur = start_of_string ? 1'b0      : partial_r;

    // Ten times the size plus the digit, with four guard bits to see overflow.
    size_prod = ({4'd0, size_cur} << 3) + ({4'd0, size_cur} << 1)
              + {{SIZE_WIDTH{1'b0}}, digit};
    size_ext  = {{CSIZE_W{1'b0}}, size_cur};

    field_nxt   = fld_cur;
    type_nxt    = type_cur;
    size_nxt    = size_cur;
    sat_nxt     = sat_cur;
    remain_nxt  = remain_cur;
    partial_nxt = partial_cur;

    result = '0;
    result.kind = KIND_FRAME;

    priority if (remain_cur != SIZE_ZERO) begin
      // Content bytes pass through whatever their value.
      result.kind      = KIND_CONTENT;
      result.data_byte = byte_value;
      remain_nxt       = remain_cur - SIZE_ONE;
      result.record_done = (remain_cur == SIZE_ONE);
    end else if (byte_value == BAR_CHAR) begin
      result.record_discarded = partial_cur;
      field_nxt   = FLD_NAME;
      type_nxt    = 8'd0;
      size_nxt    = SIZE_ZERO;
      sat_nxt     = 1'b0;
      partial_nxt = 1'b0;
    end else if (byte_value == COMMA_CHAR) begin
      partial_nxt = 1'b1;
      unique case (fld_cur)
        FLD_NAME: field_nxt = FLD_TYPE;
        FLD_TYPE: field_nxt = FLD_SIZE;
        default: begin
          // Third comma: report the header and arm the content countdown.
          result.header_done   = 1'b1;
          result.member_type   = type_cur;
          result.rec_size      = size_ext[CSIZE_W-1:0];
          result.size_overflow = sat_cur;
          result.record_done   = (size_cur == SIZE_ZERO);
          remain_nxt  = size_cur;
          field_nxt   = FLD_NAME;
          type_nxt    = 8'd0;
          size_nxt    = SIZE_ZERO;
          sat_nxt     = 1'b0;
          partial_nxt = 1'b0;
        end
      endcase
    end else begin
      partial_nxt = 1'b1;
      if (fld_cur == FLD_NAME) begin
        result.kind      = KIND_NAME;
        result.data_byte = byte_value;
      end else if (is_digit) begin
        if (fld_cur == FLD_TYPE) begin
          type_nxt = type_cur * DEC_BASE + {4'd0, digit};
        end else if (size_prod[SIZE_WIDTH+3:SIZE_WIDTH] != 4'd0) begin
          size_nxt = SIZE_MAX;
          sat_nxt  = 1'b1;
        end else begin
          size_nxt = size_prod[SIZE_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r   <= FLD_NAME;
      type_r    <= 8'd0;
      size_r    <= SIZE_ZERO;
      sat_r     <= 1'b0;
      remain_r  <= SIZE_ZERO;
      partial_r <= 1'b0;
    end else if (step) begin
      field_r   <= field_nxt;
      type_r    <= type_nxt;
      size_r    <= size_nxt;
      sat_r     <= sat_nxt;
      remain_r  <= remain_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

### hw/rtl/length_prefixed_record_parser_top.sv
// Top level of the length-prefixed record parser: input stage, parser and result register.
//
// Channel | Direction | Ports                        | Contents
// in_     | slave     | tvalid, tready, tdata, tuser | one byte of the serialised string
// out_    | master    | tvalid, tready, tdata, tuser, tlast | one parse result per byte
//
// Every accepted byte yields exactly one result transaction, via the input register and then
// the result register. The parser state is updated on each parsed byte, so a byte can be
// accepted on every clock while the output is not stalled; the limit is the state update loop.
// Reset (rst_n low, synchronous) empties both register stages and clears the parser state.
// When out_tready is low the result register holds, the input register fills, and
// in_tready then drops until the result transaction completes.
module length_prefixed_record_parser_top
  import lprp_pkg::*;
#(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] byte_value
  input  logic                   in_tuser,   // [0] start_of_string
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [8] header_done,
                                             // [16:9] member_type, [48:17] rec_size,
                                             // [49] size_overflow, [50] record_discarded,
                                             // [55:51] zero
  output logic [1:0]             out_tuser,  // [1:0] kind
  output logic                   out_tlast   // record_done
);

  // Input stage: holds one accepted byte until the parser can take it.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_sos_r;

  // Result stage.
  logic       out_valid_r;
  res_t       out_res_r;

  logic       fire;
  res_t       step_res;

  // A byte is parsed when it sits in the input stage and the result register is free.
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_sos_r  <= in_tuser;
    end
  end

  lprp_parser #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (fire),
    .byte_value      (in_byte_r),
    .start_of_string (in_sos_r),
    .result          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.record_done;
  assign out_tdata  = {5'd0,
                       out_res_r.record_discarded,
                       out_res_r.size_overflow,
                       out_res_r.rec_size,
                       out_res_r.member_type,
                       out_res_r.header_done,
                       out_res_r.data_byte};

  // A header is only ever reported on a framing comma, never on a passed-through byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tuser == KIND_FRAME)
    else $error("header reported on a name or content byte");

  // A dropped record is flagged only on a bar, which never also completes a record.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[50] |-> out_tuser == KIND_FRAME && !out_tlast && !out_tdata[8])
    else $error("discard flag combined with another event");

  // Name bytes never end a record.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_NAME |-> !out_tlast)
    else $error("record ended on a name byte");

  // Every parsed byte lands in the result register on the next edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("parsed byte produced no result");

endmodule
